// ===== rtl/core/lru_write_back_cluster_cache_assert.svh =====
// Assertion macros for the LRU write-back cluster cache checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LRU_WRITE_BACK_CLUSTER_CACHE_ASSERT_SVH
`define LRU_WRITE_BACK_CLUSTER_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWBCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lwbcc check failed");

// The consequent must hold in the cycle after the antecedent.
`define LWBCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lwbcc check failed");

`endif

// ===== rtl/core/lwbcc_pkg.sv =====
// Shared types and constants for the LRU write-back cluster cache.
// Used by the controller, the datapath, the top level and the checker.
package lwbcc_pkg;

  localparam int MAX_LINES = 16;

  localparam logic [1:0] OP_READ      = 2'd0;
  localparam logic [1:0] OP_WRITE     = 2'd1;
  localparam logic [1:0] OP_FLUSH_ONE = 2'd2;
  localparam logic [1:0] OP_FLUSH_ALL = 2'd3;

  localparam logic [4:0] LINES_IN_USE_RST = 5'd16;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] cluster;
  } in_t;

  typedef struct packed {
    logic [3:0]  line;
    logic        hit;
    logic        writeback;
    logic [31:0] writeback_cluster;
    logic        fill;
    logic        last;
  } out_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
    logic walk_step;
  } cmd_t;

  typedef struct packed {
    logic flush_all;
    logic out_free;
    logic walk_last;
  } stat_t;

endpackage

// ===== rtl/core/lwbcc_ctrl.sv =====
// Sequencing state machine for the LRU write-back cluster cache.
// Depends on lwbcc_pkg for the command and status structs.
module lwbcc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lwbcc_pkg::stat_t stat,
  output lwbcc_pkg::cmd_t  cmd
);
  import lwbcc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_WALK   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = stat.flush_all ? S_WALK : S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = S_LOOKUP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WALK: begin
        if (stat.out_free) begin
          cmd.walk_step = 1'b1;
          if (stat.walk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/lwbcc_dp.sv =====
// Directory datapath: tags, valid and dirty marks, recency ranks, lookup
// registers, the flush-all walk counter and the result register. Uses lwbcc_pkg.
module lwbcc_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  input  lwbcc_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lwbcc_pkg::out_t  out_data,
  input  lwbcc_pkg::cmd_t  cmd,
  output lwbcc_pkg::stat_t stat
);
  import lwbcc_pkg::*;

  localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  logic [31:0]          tag_r    [MAX_LINES];
  logic [31:0]          tag_nxt  [MAX_LINES];
  logic [IW-1:0]        rank_r   [MAX_LINES];
  logic [IW-1:0]        rank_nxt [MAX_LINES];
  logic [MAX_LINES-1:0] valid_r, valid_nxt;
  logic [MAX_LINES-1:0] dirty_r, dirty_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [4:0]           cfg_r, cfg_nxt;
  in_t                  item_r, item_nxt;
  logic                 hit_r, hit_nxt;
  logic                 room_r, room_nxt;
  logic [IW-1:0]        hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic [IW-1:0]        victim_idx_r, victim_idx_nxt;
  logic [IW-1:0]        walk_r, walk_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic [MAX_LINES-1:0] match_v, free_v, oldest_v, walk_v;
  logic [IW-1:0]        last_rank;
  logic [IW-1:0]        acc_ln;
  logic [IW-1:0]        walk_ln;
  logic [IW-1:0]        hit_rank;
  logic [LW-1:0]        cfg_ext, lim;
  logic                 wr;
  logic                 walk_last;
  logic                 evict_wb;

  function automatic logic [IW-1:0] onehot_idx(input logic [MAX_LINES-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_LINES; i++) begin
      if (v[i]) begin
        r = r | IW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] lowest_idx(input logic [MAX_LINES-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = MAX_LINES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IW'(i);
      end
    end
    return r;
  endfunction

  assign last_rank = IW'(count_r - CW'(1));

  always_comb begin
    for (int i = 0; i < MAX_LINES; i++) begin
      match_v[i]  = valid_r[i] && (tag_r[i] == item_r.cluster);
      free_v[i]   = !valid_r[i];
      oldest_v[i] = valid_r[i] && (rank_r[i] == last_rank);
      walk_v[i]   = valid_r[i] && (rank_r[i] == walk_r);
    end
  end

  assign cfg_ext   = LW'(cfg_r);
  assign lim       = (cfg_ext == '0) ? LW'(1) :
                     ((cfg_ext > LW'(MAX_LINES)) ? LW'(MAX_LINES) : cfg_ext);
  assign wr        = (item_r.op == OP_WRITE);
  assign acc_ln    = hit_r ? hit_idx_r : (room_r ? free_idx_r : victim_idx_r);
  assign hit_rank  = rank_r[hit_idx_r];
  assign walk_ln   = onehot_idx(walk_v);
  assign walk_last = (count_r == '0) || (walk_r == last_rank);
  assign evict_wb  = !room_r && dirty_r[acc_ln];

  always_comb begin
    tag_nxt        = tag_r;
    rank_nxt       = rank_r;
    valid_nxt      = valid_r;
    dirty_nxt      = dirty_r;
    count_nxt      = count_r;
    cfg_nxt        = cfg_we ? cfg_wdata : cfg_r;
    item_nxt       = cmd.capture ? in_data : item_r;
    hit_nxt        = hit_r;
    room_nxt       = room_r;
    hit_idx_nxt    = hit_idx_r;
    free_idx_nxt   = free_idx_r;
    victim_idx_nxt = victim_idx_r;
    walk_nxt       = walk_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (cmd.lookup) begin
      hit_nxt        = |match_v;
      hit_idx_nxt    = onehot_idx(match_v);
      room_nxt       = LW'(count_r) < lim;
      free_idx_nxt   = lowest_idx(free_v);
      victim_idx_nxt = onehot_idx(oldest_v);
      walk_nxt       = '0;
    end

    if (cmd.commit) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt      = '0;
      out_data_nxt.last = 1'b1;
      if (item_r.op == OP_FLUSH_ONE) begin
        if (hit_r) begin
          out_data_nxt.line      = 4'(hit_idx_r);
          out_data_nxt.hit       = 1'b1;
          out_data_nxt.writeback = dirty_r[hit_idx_r];
          out_data_nxt.writeback_cluster = dirty_r[hit_idx_r] ? tag_r[hit_idx_r] : '0;
          for (int i = 0; i < MAX_LINES; i++) begin
            if (valid_r[i] && (rank_r[i] > hit_rank)) begin
              rank_nxt[i] = rank_r[i] - IW'(1);
            end
          end
          valid_nxt[hit_idx_r] = 1'b0;
          dirty_nxt[hit_idx_r] = 1'b0;
          count_nxt            = count_r - CW'(1);
        end
      end else if (hit_r) begin
        for (int i = 0; i < MAX_LINES; i++) begin
          if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        rank_nxt[hit_idx_r] = '0;
        if (wr) begin
          dirty_nxt[hit_idx_r] = 1'b1;
        end
        out_data_nxt.line = 4'(hit_idx_r);
        out_data_nxt.hit  = 1'b1;
      end else begin
        for (int i = 0; i < MAX_LINES; i++) begin
          if (valid_r[i] && (i != int'(acc_ln))) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        rank_nxt[acc_ln]  = '0;
        valid_nxt[acc_ln] = 1'b1;
        tag_nxt[acc_ln]   = item_r.cluster;
        dirty_nxt[acc_ln] = wr;
        if (room_r) begin
          count_nxt = count_r + CW'(1);
        end
        out_data_nxt.line      = 4'(acc_ln);
        out_data_nxt.fill      = 1'b1;
        out_data_nxt.writeback = evict_wb;
        out_data_nxt.writeback_cluster = evict_wb ? tag_r[acc_ln] : '0;
      end
    end

    if (cmd.walk_step) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt      = '0;
      out_data_nxt.last = walk_last;
      if (count_r != '0) begin
        out_data_nxt.line      = 4'(walk_ln);
        out_data_nxt.hit       = 1'b1;
        out_data_nxt.writeback = dirty_r[walk_ln];
        out_data_nxt.writeback_cluster = dirty_r[walk_ln] ? tag_r[walk_ln] : '0;
      end
      walk_nxt = walk_r + IW'(1);
      if (walk_last) begin
        valid_nxt = '0;
        dirty_nxt = '0;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dirty_r     <= '0;
      count_r     <= '0;
      cfg_r       <= LINES_IN_USE_RST;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      count_r     <= count_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r        <= tag_nxt;
    rank_r       <= rank_nxt;
    item_r       <= item_nxt;
    hit_r        <= hit_nxt;
    room_r       <= room_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    victim_idx_r <= victim_idx_nxt;
    walk_r       <= walk_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign stat.flush_all = (item_r.op == OP_FLUSH_ALL);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.walk_last = walk_last;

endmodule

// ===== rtl/core/lru_write_back_cluster_cache.sv =====
// Access and flush-one: lookup state, then commit state, which registers the result once
// the result register is free; a new item is taken in idle or in that commit. Flush-all:
// max(1, valid lines) results in rank order, one line per cycle while results do not stall.
// Synchronous active-low reset clears all valid and dirty marks and the line count
// at once and sets lines_in_use to 16; no clearing pass follows.
module lru_write_back_cluster_cache (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  lwbcc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lwbcc_pkg::out_t out_data
);
  import lwbcc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lwbcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lwbcc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/core/lwbcc_checker.sv =====
// Port-level checks for the LRU write-back cluster cache, bound to the top level.
// Depends on lwbcc_pkg and the assertion macro header.
`include "lru_write_back_cluster_cache_assert.svh"

module lwbcc_port_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lwbcc_pkg::out_t out_data
);
  import lwbcc_pkg::*;

  `LWBCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `LWBCC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `LWBCC_ASSERT_SAME(a_fill_is_miss, out_valid && out_data.fill, out_data.last && !out_data.hit)
  `LWBCC_ASSERT_SAME(a_wb_cluster_zero, out_valid && !out_data.writeback, out_data.writeback_cluster == '0)

endmodule

bind lru_write_back_cluster_cache lwbcc_port_checker u_lwbcc_checker (.*);

// ===== sim/lwbcc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the LRU write-back cluster cache: keeps its own copy of the line directory,
// works out the results of every accepted item and compares them with the result channel.
// Depends on lwbcc_pkg for the item and result types and the operation codes.
module lwbcc_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_wdata,
  input  logic            in_valid,
  input  logic            in_ready,
  input  lwbcc_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  lwbcc_pkg::out_t out_data,
  output int              mismatches,
  output int              results_due
);
  import lwbcc_pkg::*;

  localparam int LINES = 16;
  localparam int MAX_PRINTED = 40;

  logic [31:0] dir_tag [LINES];
  bit          dir_valid [LINES];
  bit          dir_dirty [LINES];
  int          dir_rank [LINES];
  int          dir_count;
  int          line_limit;
  out_t        due_results [$];
  out_t        want;

  initial begin
    mismatches = 0;
    results_due = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
    end
  endtask

  function automatic void promote_line(int ln, int old_rank);
    for (int i = 0; i < LINES; i++) begin
      if (dir_valid[i] && i != ln && dir_rank[i] < old_rank) dir_rank[i]++;
    end
    dir_rank[ln] = 0;
  endfunction

  task automatic apply_directory_op(in_t item);
    int   hit_ln;
    int   ln;
    int   best;
    int   n;
    int   total;
    int   lim;
    bit   found;
    out_t res;
    hit_ln = -1;
    for (int i = 0; i < LINES; i++) begin
      if (dir_valid[i] && dir_tag[i] == item.cluster && hit_ln < 0) hit_ln = i;
    end
    lim = (line_limit < 1) ? 1 : (line_limit > LINES) ? LINES : line_limit;
    res = '0;
    case (item.op)
      OP_READ, OP_WRITE: begin
        if (hit_ln >= 0) begin
          promote_line(hit_ln, dir_rank[hit_ln]);
          if (item.op == OP_WRITE) dir_dirty[hit_ln] = 1'b1;
          res.line = hit_ln[3:0];
          res.hit = 1'b1;
        end else begin
          ln = -1;
          if (dir_count < lim) begin
            for (int i = 0; i < LINES; i++) begin
              if (!dir_valid[i] && ln < 0) ln = i;
            end
          end
          if (ln >= 0) begin
            dir_valid[ln] = 1'b1;
            dir_count++;
          end else begin
            best = 0;
            found = 1'b0;
            for (int i = 0; i < LINES; i++) begin
              if (dir_valid[i] && (!found || dir_rank[i] > dir_rank[best])) begin
                best = i;
                found = 1'b1;
              end
            end
            ln = best;
            if (!found) begin
              dir_valid[ln] = 1'b1;
              dir_count++;
              dir_dirty[ln] = 1'b0;
            end
            if (dir_dirty[ln]) begin
              res.writeback = 1'b1;
              res.writeback_cluster = dir_tag[ln];
            end
          end
          promote_line(ln, LINES + 1);
          dir_tag[ln] = item.cluster;
          dir_dirty[ln] = (item.op == OP_WRITE);
          res.line = ln[3:0];
          res.fill = 1'b1;
        end
        res.last = 1'b1;
        due_results.push_back(res);
      end
      OP_FLUSH_ONE: begin
        if (hit_ln >= 0) begin
          res.line = hit_ln[3:0];
          res.hit = 1'b1;
          res.writeback = dir_dirty[hit_ln];
          if (dir_dirty[hit_ln]) res.writeback_cluster = dir_tag[hit_ln];
          for (int i = 0; i < LINES; i++) begin
            if (dir_valid[i] && i != hit_ln && dir_rank[i] > dir_rank[hit_ln]) dir_rank[i]--;
          end
          dir_valid[hit_ln] = 1'b0;
          dir_dirty[hit_ln] = 1'b0;
          dir_tag[hit_ln] = '0;
          dir_rank[hit_ln] = 0;
          if (dir_count > 0) dir_count--;
        end
        res.last = 1'b1;
        due_results.push_back(res);
      end
      OP_FLUSH_ALL: begin
        total = 0;
        for (int i = 0; i < LINES; i++) begin
          if (dir_valid[i]) total++;
        end
        n = 0;
        for (int r = 0; r < LINES; r++) begin
          for (int i = 0; i < LINES; i++) begin
            if (dir_valid[i] && dir_rank[i] == r) begin
              n++;
              res = '0;
              res.line = i[3:0];
              res.hit = 1'b1;
              res.writeback = dir_dirty[i];
              if (dir_dirty[i]) res.writeback_cluster = dir_tag[i];
              res.last = (n == total);
              due_results.push_back(res);
            end
          end
        end
        if (total == 0) begin
          res = '0;
          res.last = 1'b1;
          due_results.push_back(res);
        end
        for (int i = 0; i < LINES; i++) begin
          dir_valid[i] = 1'b0;
          dir_dirty[i] = 1'b0;
          dir_tag[i] = '0;
          dir_rank[i] = 0;
        end
        dir_count = 0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        dir_valid[i] = 1'b0;
        dir_dirty[i] = 1'b0;
        dir_tag[i] = '0;
        dir_rank[i] = 0;
      end
      dir_count = 0;
      line_limit = LINES_IN_USE_RST;
      due_results.delete();
    end else begin
      if (cfg_we) line_limit = cfg_wdata;
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no item waiting, line", 32'(out_data.line), 32'd0);
        end else begin
          want = due_results.pop_front();
          if (out_data.line != want.line) begin
            report_mismatch("line", 32'(out_data.line), 32'(want.line));
          end
          if (out_data.hit != want.hit) begin
            report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
          end
          if (out_data.writeback != want.writeback) begin
            report_mismatch("writeback", 32'(out_data.writeback), 32'(want.writeback));
          end
          if (out_data.writeback_cluster != want.writeback_cluster) begin
            report_mismatch("writeback_cluster", out_data.writeback_cluster,
                            want.writeback_cluster);
          end
          if (out_data.fill != want.fill) begin
            report_mismatch("fill", 32'(out_data.fill), 32'(want.fill));
          end
          if (out_data.last != want.last) begin
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
          end
        end
      end
      if (in_valid && in_ready) apply_directory_op(in_data);
    end
    results_due <= due_results.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the LRU write-back cluster cache: clock, reset, item and
// register stimulus, result-side stalls and the verdict. Depends on lwbcc_pkg and lwbcc_checker.
module tb_top;
  import lwbcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int POOL_SIZE = 24;
  localparam int PHASES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  in_t        in_data = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  out_t       out_data;

  int          mismatches;
  int          results_due;
  int          idle_cycles;
  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] cluster_pool [POOL_SIZE];
  int          phase_limit [PHASES] = '{16, 5, 31, 1, 0, 16, 2, 9};
  int          phase_items [PHASES] = '{24, 10, 10, 8, 6, 12, 8, 10};

  always #4 clk = ~clk;

  lru_write_back_cluster_cache u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lwbcc_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_idles || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(logic [1:0] op, logic [31:0] cluster);
    int  gap;
    in_t item;
    gap = pick_gap();
    item.op = op;
    item.cluster = cluster;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic set_limit(logic [4:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_items(int count);
    int          r;
    logic [1:0]  op;
    logic [31:0] cluster;
    repeat (count) begin
      r = $urandom_range(0, 99);
      op = (r < 38) ? OP_READ : (r < 76) ? OP_WRITE : (r < 94) ? OP_FLUSH_ONE : OP_FLUSH_ALL;
      if ($urandom_range(0, 99) < 85) cluster = cluster_pool[$urandom_range(0, POOL_SIZE - 1)];
      else cluster = $urandom;
      send_item(op, cluster);
    end
  endtask

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
        out_ready <= 1'b0;
        repeat (pick_stall()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    cluster_pool[0] = 32'h0000_0000;
    cluster_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) cluster_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_FLUSH_ALL, 32'h0000_0000);
    send_item(OP_FLUSH_ONE, 32'h0000_0007);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 32'h8000_0000);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_WRITE, 32'h0000_0000);
    send_item(OP_FLUSH_ONE, 32'hFFFF_FFFF);
    send_item(OP_FLUSH_ONE, 32'h0000_0000);
    send_item(OP_READ, 32'hAAAA_AAAA);
    send_item(OP_WRITE, 32'h5555_5555);
    send_item(OP_FLUSH_ALL, 32'hFFFF_FFFF);

    set_limit(5'd1);
    send_item(OP_WRITE, 32'h0000_0001);
    send_item(OP_WRITE, 32'h0000_0002);
    send_item(OP_READ, 32'h0000_0003);
    send_item(OP_READ, 32'h0000_0004);
    send_item(OP_FLUSH_ONE, 32'h0000_0004);

    set_limit(5'd0);
    send_item(OP_WRITE, 32'h0000_0009);
    send_item(OP_READ, 32'h0000_000A);
    send_item(OP_FLUSH_ALL, 32'h0000_0000);

    // Phases run back to back without flushing, so a lower limit meets a fuller directory.
    for (int k = 0; k < PHASES; k++) begin
      set_limit(phase_limit[k][4:0]);
      sender_idles = (k % 3 != 1) && (k != 0);
      receiver_stalls = (k % 3 != 1);
      if (k == 0) hold_req = 1'b1;
      send_random_items(phase_items[k]);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== lru_write_back_cluster_cache.f =====
+incdir+rtl/core
rtl/core/lwbcc_pkg.sv
rtl/core/lwbcc_ctrl.sv
rtl/core/lwbcc_dp.sv
rtl/core/lru_write_back_cluster_cache.sv
rtl/core/lwbcc_checker.sv
sim/lwbcc_checker.sv
sim/tb_top.sv
